// File: sv/wsg_pkg.sv
// ----------------------------------------------------------------------------
// Wavetable sound generator package
// Shared widths, bus command codes and the voice control bundle.
// ----------------------------------------------------------------------------
package wsg_pkg;

  localparam int WAVE_LENGTH  = 32;
  localparam int WAVE_AW      = $clog2(WAVE_LENGTH);
  localparam int CHANNELS_DEF = 3;
  localparam int SAMPLE_W     = 8;
  localparam int PITCH_W      = 12;
  localparam int VOL_W        = 4;
  localparam int MIX_W        = 11;
  localparam int BANK_W       = 6;

  typedef enum logic [1:0] {
    CMD_IDLE  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_READ  = 2'd2,
    CMD_RESET = 2'd3
  } cmd_e;

  typedef struct packed {
    logic fire;
    logic run;
    logic fch;
    logic en;
    logic t_hi;
    logic t_idx;
    logic t_pre;
  } vctl_t;

endpackage

// File: sv/wsg_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with a registered, enabled read.
// ----------------------------------------------------------------------------
module wsg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// File: sv/wsg_voice.sv
// ----------------------------------------------------------------------------
// Wavetable voice
// Pitch down counter, sample index, bit-serial volume multiply and output.
// ----------------------------------------------------------------------------
module wsg_voice (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  wsg_pkg::vctl_t                ctl_i,
  input  logic [wsg_pkg::PITCH_W-1:0]   pitch_i,
  input  logic [wsg_pkg::VOL_W-1:0]     volume_i,
  input  logic [wsg_pkg::SAMPLE_W-1:0]  data_i,
  output logic [wsg_pkg::WAVE_AW-1:0]   sidx_o,
  output logic [wsg_pkg::SAMPLE_W-1:0]  level_o
);

  logic [wsg_pkg::PITCH_W-1:0]  pc_q, pc_d;
  logic [wsg_pkg::WAVE_AW-1:0]  sidx_q, sidx_d;
  logic                         step_q, step_d;
  logic [3:0]                   bcc_q, bcc_d;
  logic                         run_q, run_d;
  logic                         ser_q, ser_d;
  logic [wsg_pkg::VOL_W-1:0]    vl_q, vl_d;
  logic [4:0]                   accp_q, accp_d;
  logic [2:0]                   accl_q, accl_d;
  logic                         arm_q, arm_d;
  logic                         go_q, go_d;
  logic [wsg_pkg::SAMPLE_W-1:0] ch_q, ch_d;

  logic       lo_b, mid_b, hi_b, hi_cnt, ld, so, diff, wc, arm_r, go_r;
  logic [4:0] wv, acc, acc_sh;
  logic [wsg_pkg::SAMPLE_W-1:0] ch_r;

  always_comb begin
    lo_b   = (pc_q[3:0] == 4'd0);
    mid_b  = (pc_q[7:4] == 4'd0);
    hi_b   = (pc_q[11:8] == 4'd0);
    hi_cnt = ctl_i.t_hi | (lo_b & mid_b);
    ld     = !(ctl_i.fch | step_q);
    if (ld) begin
      pc_d = {pc_q[11:8] - {3'b0, hi_cnt}, pc_q[7:4] - {3'b0, lo_b}, pc_q[3:0] - 4'd1};
    end else begin
      pc_d = pitch_i;
    end
    step_d = ctl_i.t_idx ? (lo_b & mid_b) : (hi_cnt & hi_b);
    if (ctl_i.t_pre && ctl_i.fch) begin
      sidx_d = '1;
    end else if (step_d) begin
      sidx_d = sidx_q - wsg_pkg::WAVE_AW'(1);
    end else begin
      sidx_d = sidx_q;
    end
    bcc_d = ld ? bcc_q + 4'd1 : 4'd0;

    run_d = !ctl_i.run | ld;
    so    = run_d & ser_q;
    ser_d = data_i[bcc_q[2:0]];
    if (!ctl_i.run) begin
      vl_d = '0;
    end else if (!run_q && run_d) begin
      vl_d = volume_i;
    end else begin
      vl_d = vl_q;
    end
    diff   = so ^ ser_d;
    wv     = diff ? {ser_d, vl_d ^ {4{ser_d}}} : 5'd0;
    wc     = diff & ser_d;
    acc    = run_d ? accp_q : 5'd0;
    acc_sh = {acc[4], acc[4:1]};
    accp_d = acc_sh + wv + {4'b0, wc};
    accl_d = run_d ? {acc[0], accl_q[2:1]} : 3'd0;

    arm_r = run_d & arm_q;
    go_r  = run_d & go_q;
    ch_r  = ctl_i.en ? ch_q : '0;
    arm_d = run_d & bcc_d[3] & bcc_d[0];
    go_d  = run_d & ((!arm_r & arm_d) | go_r);
    if (!ctl_i.en) begin
      ch_d = '0;
    end else if (!go_r && go_d) begin
      ch_d = {acc, accl_d};
    end else begin
      ch_d = ch_r;
    end
  end

  assign sidx_o  = ctl_i.fire ? sidx_d : sidx_q;
  assign level_o = ch_r;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q   <= '0;
      sidx_q <= '0;
      step_q <= 1'b0;
      bcc_q  <= '0;
      run_q  <= 1'b0;
      ser_q  <= 1'b0;
      vl_q   <= '0;
      accp_q <= '0;
      accl_q <= '0;
      arm_q  <= 1'b0;
      go_q   <= 1'b0;
      ch_q   <= '0;
    end else if (ctl_i.fire) begin
      pc_q   <= pc_d;
      sidx_q <= sidx_d;
      step_q <= step_d;
      bcc_q  <= bcc_d;
      run_q  <= run_d;
      ser_q  <= ser_d;
      vl_q   <= vl_d;
      accp_q <= accp_d;
      accl_q <= accl_d;
      arm_q  <= arm_d;
      go_q   <= go_d;
      ch_q   <= ch_d;
    end
  end

endmodule

// File: sv/wavetable_sound_generator.sv
// ----------------------------------------------------------------------------
// Wavetable sound generator
// Three-voice wavetable sound device with ROM bank registers.
//
//   channel  dir  tdata (low bit up)                       tuser
//   s_axis   in   address[15:0], write_data[23:16]          command[1:0]
//   m_axis   out  read_data[7:0], rom_bank[13:8],           none
//                 audio_level[24:14], zero[31:25]
//
// One item per clock cycle sustained while the output is not stalled. The
// first stage reads the per-voice wave memories, the second updates
// registers and voices and loads the output register.
// Reset clears all control state; unwritten wave bytes read as zero through
// per-entry valid bits, so no clearing pass is needed.
// A stalled output register holds its item and back-pressure reaches the
// input within the same cycle.
// ----------------------------------------------------------------------------
module wavetable_sound_generator #(
  parameter int CHANNELS = wsg_pkg::CHANNELS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [23:0] s_axis_tdata_i,   // address, write_data
  input  logic [1:0]  s_axis_tuser_i,   // command
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o    // read_data, rom_bank, audio_level
);

  localparam int AW = wsg_pkg::WAVE_AW;
  localparam int SW = wsg_pkg::SAMPLE_W;
  localparam int BW = wsg_pkg::BANK_W;
  localparam int MW = wsg_pkg::MIX_W;

  localparam logic [15:0] ADDR_MASK  = 16'hF8FF;
  localparam logic [4:0]  SND_WINDOW = 5'h13;
  localparam logic [4:0]  BANK0_WIN  = 5'h0A;
  localparam logic [4:0]  BANK1_WIN  = 5'h0E;
  localparam logic [4:0]  BANK2_WIN  = 5'h12;
  localparam logic [4:0]  BANK3_WIN  = 5'h16;
  localparam logic [BW-1:0] BANK_SEL = 6'h3F;
  localparam logic [7:0]  WAVE_END   = 8'h60;
  localparam logic [7:0]  REG_BASE   = 8'h80;
  localparam logic [7:0]  REG_END    = 8'hA0;
  localparam logic [7:0]  TEST_BASE  = 8'hE0;
  localparam logic [3:0]  REG_PITCH_END = 4'h6;
  localparam logic [3:0]  REG_VOL0   = 4'hA;
  localparam logic [3:0]  REG_VOL_LAST = 4'hC;
  localparam logic [3:0]  REG_ENABLE = 4'hF;
  localparam logic [10:0] MIX_MASK   = 11'h7FF;

  logic                 a_valid_q, b_valid_q, out_valid_q;
  wsg_pkg::cmd_e        a_cmd_q, b_cmd_q;
  logic [15:0]          a_addr_q, b_addr_q;
  logic [SW-1:0]        a_wd_q, b_wd_q;
  logic [SW-1:0]        rd_q;
  logic [BW-1:0]        rb_q;
  logic [MW-1:0]        mix_q;

  logic [3:0][BW-1:0]                      bank_q, bank_n, bank_nx;
  logic [CHANNELS-1:0][wsg_pkg::PITCH_W-1:0] pitch_q, pitch_n;
  logic [CHANNELS-1:0][wsg_pkg::VOL_W-1:0]   vol_q, vol_n;
  logic [CHANNELS-1:0]                     en_q, en_n;
  logic [SW-1:0]                           test_q, test_n;
  logic [1:0]                              ef_q;
  logic [CHANNELS-1:0][wsg_pkg::WAVE_LENGTH-1:0] wvalid_q;

  logic s_fire, a_to_b, b_fire;
  logic b_wr, b_rq, b_run, b_sel, b_wedge, b_redge, snd_we, a_sel, a_cs;
  logic [4:0] b_wreg;
  logic [7:0] b_sa;
  logic [3:0] b_r;
  logic [SW-1:0] rd_n;
  logic [BW-1:0] rb_n;
  logic [MW-1:0] mix_n;

  logic [CHANNELS-1:0]         wave_we, fch, mine_b, rok_q, fwd_q;
  logic [CHANNELS-1:0][SW-1:0] fwdd_q, rdata, data, level;
  logic [CHANNELS-1:0][AW-1:0] raddr, sidx_nx;
  wsg_pkg::vctl_t [CHANNELS-1:0] vctl;

  assign b_fire = b_valid_q && (!out_valid_q || m_axis_tready_i);
  assign a_to_b = a_valid_q && (!b_valid_q || b_fire);
  assign s_axis_tready_o = !a_valid_q || a_to_b;
  assign s_fire = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    b_wr    = (b_cmd_q == wsg_pkg::CMD_WRITE);
    b_rq    = (b_cmd_q == wsg_pkg::CMD_READ);
    b_run   = (b_cmd_q != wsg_pkg::CMD_RESET);
    b_wreg  = 5'((b_addr_q & ADDR_MASK) >> 11);
    b_sa    = b_addr_q[7:0];
    b_r     = b_sa[3:0];
    b_sel   = (b_wreg == SND_WINDOW) && (bank_q[2] == BANK_SEL);
    b_wedge = b_wr && !ef_q[0];
    b_redge = b_rq && !ef_q[1];
    snd_we  = b_wedge && b_sel;

    bank_n = bank_q;
    if (b_wedge) begin
      case (b_wreg)
        BANK0_WIN: bank_n[0] = b_wd_q[BW-1:0];
        BANK1_WIN: bank_n[1] = b_wd_q[BW-1:0];
        BANK2_WIN: bank_n[2] = b_wd_q[BW-1:0];
        BANK3_WIN: bank_n[3] = b_wd_q[BW-1:0];
        default: ;
      endcase
    end
    bank_nx = b_fire ? bank_n : bank_q;

    pitch_n = pitch_q;
    vol_n   = vol_q;
    en_n    = en_q;
    test_n  = test_q;
    if (snd_we && b_sa >= REG_BASE && b_sa < REG_END) begin
      for (int c = 0; c < CHANNELS; c++) begin
        if (b_r < REG_PITCH_END && b_r[3:1] == 3'(c)) begin
          if (b_r[0]) begin
            pitch_n[c] = {b_wd_q[3:0], pitch_q[c][7:0]};
          end else begin
            pitch_n[c] = {pitch_q[c][11:8], b_wd_q};
          end
        end
        if (b_r >= REG_VOL0 && b_r <= REG_VOL_LAST && b_r == REG_VOL0 + 4'(c)) begin
          vol_n[c] = b_wd_q[3:0];
        end
        if (b_r == REG_ENABLE && c < 3) begin
          en_n[c] = b_wd_q[c];
        end
      end
    end else if (snd_we && b_sa >= TEST_BASE) begin
      test_n = b_wd_q;
    end

    rd_n = '0;
    for (int c = 0; c < CHANNELS; c++) begin
      mine_b[c]  = b_sel && b_sa < WAVE_END && b_sa[7:5] == 3'(c);
      wave_we[c] = b_fire && snd_we && mine_b[c] && !test_q[6];
      fch[c]     = snd_we && b_sa >= REG_BASE && b_sa < REG_END &&
                   b_r < REG_PITCH_END && b_r[3:1] == 3'(c);
      if (b_wr && mine_b[c] && !test_q[6]) begin
        data[c] = b_wd_q;
      end else if (fwd_q[c]) begin
        data[c] = fwdd_q[c];
      end else begin
        data[c] = rok_q[c] ? rdata[c] : '0;
      end
      if (b_redge && b_sel && b_sa < REG_BASE && b_sa[7:5] == 3'(c) && c < 3) begin
        rd_n = data[c];
      end
      vctl[c] = '{fire: b_fire, run: b_run, fch: fch[c], en: en_n[c],
                  t_hi: test_n[0], t_idx: test_n[1], t_pre: test_n[5]};
    end

    rb_n  = bank_n[b_addr_q[14:13] ^ 2'b10];
    mix_n = '0;
    for (int c = 0; c < CHANNELS; c++) begin
      mix_n = mix_n + MW'(level[c]);
    end
    mix_n = b_run ? (mix_n & MIX_MASK) : '0;

    a_cs  = (a_cmd_q == wsg_pkg::CMD_WRITE) || (a_cmd_q == wsg_pkg::CMD_READ);
    a_sel = (5'((a_addr_q & ADDR_MASK) >> 11) == SND_WINDOW) && (bank_nx[2] == BANK_SEL);
    for (int c = 0; c < CHANNELS; c++) begin
      if (a_cs && a_sel && a_addr_q[7:0] < WAVE_END && a_addr_q[7:5] == 3'(c)) begin
        raddr[c] = a_addr_q[AW-1:0];
      end else begin
        raddr[c] = ~sidx_nx[c];
      end
    end
  end

  for (genvar g = 0; g < CHANNELS; g++) begin : g_voice
    wsg_ram #(
      .WIDTH(SW),
      .DEPTH(wsg_pkg::WAVE_LENGTH)
    ) u_ram (
      .clk_i  (clk_i),
      .we_i   (wave_we[g]),
      .waddr_i(b_sa[AW-1:0]),
      .wdata_i(b_wd_q),
      .re_i   (a_to_b),
      .raddr_i(raddr[g]),
      .rdata_o(rdata[g])
    );

    wsg_voice u_voice (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctl_i   (vctl[g]),
      .pitch_i (pitch_n[g]),
      .volume_i(vol_n[g]),
      .data_i  (data[g]),
      .sidx_o  (sidx_nx[g]),
      .level_o (level[g])
    );
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      a_cmd_q  <= wsg_pkg::cmd_e'(s_axis_tuser_i);
      a_addr_q <= s_axis_tdata_i[15:0];
      a_wd_q   <= s_axis_tdata_i[23:16];
    end
    if (a_to_b) begin
      b_cmd_q  <= a_cmd_q;
      b_addr_q <= a_addr_q;
      b_wd_q   <= a_wd_q;
      for (int c = 0; c < CHANNELS; c++) begin
        fwdd_q[c] <= b_wd_q;
      end
    end
    if (b_fire) begin
      rd_q  <= rd_n;
      rb_q  <= rb_n;
      mix_q <= mix_n;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q   <= 1'b0;
      b_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
      bank_q      <= '0;
      pitch_q     <= '0;
      vol_q       <= '0;
      en_q        <= '0;
      test_q      <= '0;
      ef_q        <= '0;
      wvalid_q    <= '0;
      rok_q       <= '0;
      fwd_q       <= '0;
    end else begin
      if (s_fire) begin
        a_valid_q <= 1'b1;
      end else if (a_to_b) begin
        a_valid_q <= 1'b0;
      end
      if (a_to_b) begin
        b_valid_q <= 1'b1;
      end else if (b_fire) begin
        b_valid_q <= 1'b0;
      end
      if (b_fire) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
      if (b_fire) begin
        bank_q  <= bank_n;
        pitch_q <= pitch_n;
        vol_q   <= vol_n;
        en_q    <= en_n;
        test_q  <= test_n;
        ef_q    <= {b_rq, b_wr};
      end
      for (int c = 0; c < CHANNELS; c++) begin
        if (wave_we[c]) begin
          wvalid_q[c][b_sa[AW-1:0]] <= 1'b1;
        end
        if (a_to_b) begin
          rok_q[c] <= wvalid_q[c][raddr[c]];
          fwd_q[c] <= wave_we[c] && (raddr[c] == b_sa[AW-1:0]);
        end
      end
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {7'b0, mix_q, rb_q, rd_q};

  a_hold_when_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (a_valid_q && b_valid_q && !b_fire) |-> !s_axis_tready_o)
    else $error("input accepted while both stages are blocked");

  a_read_fills_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    a_to_b |=> b_valid_q)
    else $error("wave read issued without an item entering the update stage");

  a_reset_silences: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (b_fire && b_cmd_q == wsg_pkg::CMD_RESET) |=> (m_axis_tdata_o[24:14] == '0))
    else $error("audio level not zero after a reset-pin item");

  a_wave_write_sel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (|wave_we) |-> (b_fire && b_sel && b_wr))
    else $error("wave memory written outside a selected bus write");

endmodule

// File: tb/sv/wavetable_sound_generator_tb.sv
// ----------------------------------------------------------------------------
// Wavetable sound generator testbench
// Streams bus cycles (idle, write, read, reset pin low) into the block with
// random gaps and output stalls. A cycle-accurate model of the bank
// registers, wave memories, pitch counters, serial multipliers and mixer
// predicts every output item, which is checked field by field in order.
// ----------------------------------------------------------------------------
module wavetable_sound_generator_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NCH       = 3;
  localparam int IDLE_LIMIT = 20000;

  typedef struct packed {
    wsg_pkg::cmd_e cmd;
    logic [15:0]   addr;
    logic [7:0]    wdata;
  } bus_cycle_t;

  typedef struct packed {
    logic [7:0]  rdata;
    logic [5:0]  bank;
    logic [10:0] level;
  } chip_out_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [23:0] s_axis_tdata_i = '0;
  logic [1:0]  s_axis_tuser_i = wsg_pkg::CMD_IDLE;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [31:0] m_axis_tdata_o;

  wavetable_sound_generator u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Chip model state.
  logic [5:0]  rom_bank_regs [4];
  logic [7:0]  wave_mem [NCH*32];
  logic [11:0] pitch_reg [NCH];
  logic [3:0]  vol_reg [NCH];
  logic        chan_en [NCH];
  logic [7:0]  test_r;
  logic [11:0] pitch_cnt [NCH];
  logic [4:0]  sidx [NCH];
  logic [3:0]  bitc [NCH];
  logic [4:0]  macc [NCH];
  logic [7:0]  chout [NCH];
  logic        last_wr, last_rd;
  logic        idx_step [NCH];
  logic        run [NCH], run_old [NCH];
  logic        ser_now [NCH], ser_old [NCH];
  logic [3:0]  vol_lat [NCH];
  logic [4:0]  acc_pend [NCH];
  logic [2:0]  acc_low [NCH];
  logic        arm [NCH], arm_old [NCH], go [NCH], go_old [NCH];
  logic [10:0] mix;

  function automatic logic [4:0] shift_add(logic [4:0] acc, logic [4:0] wv, logic wc);
    logic [4:0] a;
    a = {acc[4], acc[4:1]};
    return a + wv + 5'(wc);
  endfunction

  function automatic void voice_mult(int c, bit rise, bit res, bit ld, logic [7:0] data);
    logic [4:0] wv;
    logic       wc;
    wv = '0;
    wc = 1'b0;
    if (!res) run[c] = 1'b1;
    else if (rise) run[c] = ld;
    if (!run[c]) ser_old[c] = 1'b0;
    else if (rise) ser_old[c] = ser_now[c];
    if (rise) ser_now[c] = data[bitc[c][2:0]];
    if (!res) vol_lat[c] = '0;
    else if (!run_old[c] && run[c]) vol_lat[c] = vol_reg[c];
    if (ser_old[c] != ser_now[c]) begin
      wv = {ser_now[c], vol_lat[c] ^ {4{ser_now[c]}}};
      wc = ser_now[c];
    end
    if (!run[c]) macc[c] = '0;
    else if (rise) macc[c] = acc_pend[c];
    acc_pend[c] = shift_add(macc[c], wv, wc);
    if (!run[c]) acc_low[c] = '0;
    else if (rise) acc_low[c] = {macc[c][0], acc_low[c][2:1]};
    if (!run[c]) arm[c] = 1'b0;
    else if (!rise) arm[c] = bitc[c][3] && bitc[c][0];
    if (!run[c]) go[c] = 1'b0;
    else if (!arm_old[c] && arm[c]) go[c] = 1'b1;
    if (!chan_en[c]) chout[c] = '0;
    else if (!go_old[c] && go[c]) chout[c] = {macc[c], acc_low[c]};
    go_old[c]  = go[c];
    arm_old[c] = arm[c];
    run_old[c] = run[c];
  endfunction

  function automatic void voice_count(int c, bit ld, bit fch);
    logic [3:0] lo, mid, hi;
    logic       lo_b, mid_b, hi_b, hi_cnt;
    {hi, mid, lo} = pitch_cnt[c];
    lo_b   = (lo == 0);
    mid_b  = (mid == 0);
    hi_b   = (hi == 0);
    hi_cnt = test_r[0] ? 1'b1 : (lo_b && mid_b);
    bitc[c] = ld ? bitc[c] + 4'd1 : 4'd0;
    if (!ld) begin
      pitch_cnt[c] = pitch_reg[c];
    end else begin
      if (hi_cnt) hi = hi - 4'd1;
      if (lo_b) mid = mid - 4'd1;
      lo = lo - 4'd1;
      pitch_cnt[c] = {hi, mid, lo};
    end
    idx_step[c] = test_r[1] ? (lo_b && mid_b) : (hi_cnt && hi_b);
    if (test_r[5] && fch) sidx[c] = 5'h1F;
    else if (idx_step[c]) sidx[c] = sidx[c] - 5'd1;
  endfunction

  function automatic void chip_half(bus_cycle_t bc, bit rise, inout logic [7:0] rd);
    logic       cs, wr, rq, res, sel, wedge, redge, mine;
    logic [15:0] a;
    logic [4:0] wreg, pos;
    logic [7:0] sa;
    logic [2:0] region;
    logic [3:0] r;
    logic [7:0] data [NCH];
    logic       ld [NCH], fch [NCH];
    int         s;
    wr = (bc.cmd == wsg_pkg::CMD_WRITE);
    rq = (bc.cmd == wsg_pkg::CMD_READ);
    cs = wr || rq;
    res = (bc.cmd != wsg_pkg::CMD_RESET);
    a = bc.addr & 16'hF8FF;
    wreg = a[15:11];
    sel = (wreg == 5'h13) && (rom_bank_regs[2] == 6'h3F);
    sa = a[7:0];
    region = sa[7:5];
    r = sa[3:0];
    wedge = wr && !last_wr;
    redge = rq && !last_rd;
    if (wedge) begin
      case (wreg)
        5'h0A: rom_bank_regs[0] = bc.wdata[5:0];
        5'h0E: rom_bank_regs[1] = bc.wdata[5:0];
        5'h12: rom_bank_regs[2] = bc.wdata[5:0];
        5'h16: rom_bank_regs[3] = bc.wdata[5:0];
        default: ;
      endcase
    end
    last_wr = wr;
    last_rd = rq;
    if (wedge && sel) begin
      if (sa < 8'h60) begin
        if (!test_r[6]) wave_mem[region*32 + sa[4:0]] = bc.wdata;
      end else if (sa >= 8'h80 && sa < 8'hA0) begin
        if (r < 6) begin
          if (r[0]) pitch_reg[r>>1][11:8] = bc.wdata[3:0];
          else pitch_reg[r>>1][7:0] = bc.wdata;
        end else if (r >= 4'hA && r <= 4'hC) begin
          vol_reg[r-4'hA] = bc.wdata[3:0];
        end else if (r == 4'hF) begin
          for (int c = 0; c < NCH; c++) chan_en[c] = bc.wdata[c];
        end
      end else if (sa >= 8'hE0) begin
        test_r = bc.wdata;
      end
    end
    for (int c = 0; c < NCH; c++) begin
      mine = sel && sa < 8'h60 && region == c;
      pos = (cs && mine) ? sa[4:0] : ~sidx[c];
      fch[c] = wedge && sel && sa >= 8'h80 && sa < 8'hA0 && r < 6 && (r >> 1) == c;
      data[c] = (wr && mine && !test_r[6]) ? bc.wdata : wave_mem[c*32 + pos];
      ld[c] = !(fch[c] || idx_step[c]);
    end
    if (redge && sel && sa < 8'h80) rd = (region < 3) ? data[region] : 8'h00;
    for (int c = 0; c < NCH; c++) voice_mult(c, rise, res, ld[c], data[c]);
    if (rise)
      for (int c = 0; c < NCH; c++) voice_count(c, ld[c], fch[c]);
    if (!res) begin
      mix = '0;
    end else if (rise) begin
      s = 0;
      for (int c = 0; c < NCH; c++) s += chout[c];
      mix = 11'(s);
    end
  endfunction

  function automatic chip_out_t chip_cycle(bus_cycle_t bc);
    chip_out_t o;
    logic [7:0] rd;
    rd = '0;
    chip_half(bc, 1'b1, rd);
    chip_half(bc, 1'b0, rd);
    o.rdata = rd;
    o.bank  = rom_bank_regs[bc.addr[14:13] ^ 2'd2];
    o.level = mix;
    return o;
  endfunction

  initial begin
    foreach (rom_bank_regs[i]) rom_bank_regs[i] = '0;
    foreach (wave_mem[i]) wave_mem[i] = '0;
    for (int c = 0; c < NCH; c++) begin
      pitch_reg[c] = '0; vol_reg[c] = '0; chan_en[c] = 1'b0; pitch_cnt[c] = '0;
      sidx[c] = '0; bitc[c] = '0; macc[c] = '0; chout[c] = '0; idx_step[c] = 1'b0;
      run[c] = 1'b0; run_old[c] = 1'b0; ser_now[c] = 1'b0; ser_old[c] = 1'b0;
      vol_lat[c] = '0; acc_pend[c] = '0; acc_low[c] = '0; arm[c] = 1'b0;
      arm_old[c] = 1'b0; go[c] = 1'b0; go_old[c] = 1'b0;
    end
    test_r = '0;
    last_wr = 1'b0;
    last_rd = 1'b0;
    mix = '0;
  end

  bus_cycle_t pending_cycles[$];
  chip_out_t  expected_outs[$];
  int         errors = 0;
  int         in_gap = 0;
  int         out_gap = 0;
  int         quiet_cycles = 0;

  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 45) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  // Driver.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_o)
        expected_outs.push_back(chip_cycle({wsg_pkg::cmd_e'(s_axis_tuser_i),
                                            s_axis_tdata_i[15:0], s_axis_tdata_i[23:16]}));
      if (!s_axis_tvalid_i || s_axis_tready_o) begin
        if (in_gap > 0) begin
          in_gap <= in_gap - 1;
          s_axis_tvalid_i <= 1'b0;
        end else if (pending_cycles.size() > 0) begin
          bus_cycle_t bc;
          bc = pending_cycles.pop_front();
          s_axis_tvalid_i <= 1'b1;
          s_axis_tdata_i  <= {bc.wdata, bc.addr};
          s_axis_tuser_i  <= bc.cmd;
          in_gap <= pick_gap();
        end else begin
          s_axis_tvalid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor and output stall.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
    end else begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        chip_out_t got, want;
        got = {m_axis_tdata_o[7:0], m_axis_tdata_o[13:8], m_axis_tdata_o[24:14]};
        if (expected_outs.size() == 0) begin
          $display("%0t: unexpected item, actual %h", $realtime, m_axis_tdata_o);
          errors++;
        end else begin
          want = expected_outs.pop_front();
          if (got.rdata !== want.rdata) begin
            $display("%0t: read_data expected %h actual %h", $realtime, want.rdata, got.rdata);
            errors++;
          end
          if (got.bank !== want.bank) begin
            $display("%0t: rom_bank expected %h actual %h", $realtime, want.bank, got.bank);
            errors++;
          end
          if (got.level !== want.level) begin
            $display("%0t: audio_level expected %h actual %h", $realtime, want.level,
                     got.level);
            errors++;
          end
          if (m_axis_tdata_o[31:25] !== '0) begin
            $display("%0t: pad bits expected 0 actual %h", $realtime, m_axis_tdata_o[31:25]);
            errors++;
          end
        end
      end
      if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= 1'b1;
        out_gap <= ($urandom_range(0, 2) == 0) ? pick_gap() : 0;
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic put(wsg_pkg::cmd_e cmd, logic [15:0] addr, logic [7:0] wdata);
    pending_cycles.push_back({cmd, addr, wdata});
  endtask

  // Access then one or two idle items so the next strobe is a fresh edge.
  task automatic access(wsg_pkg::cmd_e cmd, logic [15:0] addr, logic [7:0] wdata);
    put(cmd, addr, wdata);
    repeat ($urandom_range(1, 2)) put(wsg_pkg::CMD_IDLE, 16'($urandom), 8'($urandom));
  endtask

  function automatic logic [15:0] snd_addr(logic [7:0] off);
    return {5'h13, 3'($urandom), off};
  endfunction

  initial begin
    int         kind;
    logic [7:0] off;
    // Directed cycles.
    put(wsg_pkg::CMD_RESET, 16'hFFFF, 8'hFF);
    access(wsg_pkg::CMD_READ, 16'h9800, 8'h00);
    access(wsg_pkg::CMD_WRITE, 16'h5000, 8'hFF);
    access(wsg_pkg::CMD_WRITE, 16'h7700, 8'h2A);
    access(wsg_pkg::CMD_WRITE, 16'hB000, 8'h00);
    access(wsg_pkg::CMD_WRITE, 16'h9000, 8'h3F);
    access(wsg_pkg::CMD_WRITE, 16'h9800, 8'hFF);
    access(wsg_pkg::CMD_WRITE, 16'h983F, 8'h80);
    access(wsg_pkg::CMD_WRITE, 16'h985F, 8'h7F);
    access(wsg_pkg::CMD_WRITE, 16'h9880, 8'h03);
    access(wsg_pkg::CMD_WRITE, 16'h9885, 8'hFF);
    access(wsg_pkg::CMD_WRITE, 16'h988A, 8'h0F);
    access(wsg_pkg::CMD_WRITE, 16'h988C, 8'hF8);
    access(wsg_pkg::CMD_WRITE, 16'h988F, 8'h07);
    access(wsg_pkg::CMD_READ, 16'h9820, 8'h00);
    access(wsg_pkg::CMD_READ, 16'h98A0, 8'h00);
    put(wsg_pkg::CMD_WRITE, 16'h9801, 8'h55);
    put(wsg_pkg::CMD_WRITE, 16'h9802, 8'hAA);
    put(wsg_pkg::CMD_READ, 16'h9801, 8'h00);
    put(wsg_pkg::CMD_READ, 16'h9802, 8'h00);
    access(wsg_pkg::CMD_WRITE, 16'h98E0, 8'h23);
    access(wsg_pkg::CMD_WRITE, 16'h9882, 8'h01);
    access(wsg_pkg::CMD_WRITE, 16'h98FF, 8'h40);
    access(wsg_pkg::CMD_WRITE, 16'h9810, 8'h11);
    access(wsg_pkg::CMD_WRITE, 16'h98E0, 8'h00);
    put(wsg_pkg::CMD_RESET, 16'h0000, 8'h00);
    // Random cycles, mostly well-formed sound-part accesses.
    for (int n = 0; n < 700; n++) begin
      kind = $urandom_range(0, 99);
      off = 8'($urandom);
      if (kind < 30)
        access(wsg_pkg::CMD_WRITE,
               snd_addr({1'b0, 2'($urandom_range(0, 2)), 5'($urandom)}), 8'($urandom));
      else if (kind < 42)
        access(wsg_pkg::CMD_WRITE, snd_addr({4'h8, ($urandom_range(0, 3) == 0) ? 4'($urandom)
                                                 : 4'($urandom_range(0, 5))}),
               ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 15)));
      else if (kind < 50)
        access(wsg_pkg::CMD_WRITE, snd_addr({4'h8, ($urandom_range(0, 1) == 0) ? 4'hF
                                                 : 4'($urandom_range(10, 12))}), 8'($urandom));
      else if (kind < 53)
        access(wsg_pkg::CMD_WRITE, snd_addr({3'b111, 5'($urandom)}),
               ($urandom_range(0, 2) == 0) ? 8'($urandom) : 8'h00);
      else if (kind < 70)
        access(wsg_pkg::CMD_READ, snd_addr(off), 8'($urandom));
      else if (kind < 76)
        access(wsg_pkg::CMD_WRITE, {1'b0, 2'($urandom), 2'b10, 11'($urandom)} | 16'h1000,
               ($urandom_range(0, 2) == 0) ? 8'($urandom) : 8'h3F);
      else if (kind < 78)
        put(wsg_pkg::CMD_RESET, 16'($urandom), 8'($urandom));
      else if (kind < 90)
        put(wsg_pkg::cmd_e'($urandom_range(0, 2)), 16'($urandom), 8'($urandom));
      else
        put(wsg_pkg::CMD_IDLE, 16'($urandom), 8'($urandom));
      if (kind >= 70 && kind < 76) access(wsg_pkg::CMD_WRITE, 16'h9000, 8'h3F);
    end
    wait (rst_ni);
    wait (pending_cycles.size() == 0 && !s_axis_tvalid_i && expected_outs.size() == 0);
    repeat (20) @(posedge clk_i);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

endmodule
